FILE: rtl/ofd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofd_pkg: shared types and constants of the orientation flip detector
// Register indexes, reset values, angle widths and the control word that
// drives the cells of the face-up time queue.
// ----------------------------------------------------------------------------
package ofd_pkg;

  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned LIMIT_BITS    = 15;
  localparam int unsigned ANGLE_BITS    = 16;
  localparam int unsigned MAG_BITS      = ANGLE_BITS + 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLAT_LIMIT      = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLIP_LIMIT      = 8'd3;

  localparam logic [CFG_DATA_BITS-1:0] SAMPLE_INTERVAL_RST = 32'd20000;
  localparam logic [CFG_DATA_BITS-1:0] WINDOW_LENGTH_RST   = 32'd2000000;
  localparam logic [LIMIT_BITS-1:0]    FLAT_LIMIT_RST      = 15'd2860;
  localparam logic [LIMIT_BITS-1:0]    FLIP_LIMIT_RST      = 15'd22876;

  // Broadcast to every queue cell in the same cycle
  typedef struct packed {
    logic pop;   // advance every entry one cell toward the head
    logic push;  // append the push time at the first free cell
  } cell_ctrl_t;

  // Magnitude of a signed Q3.13 angle; the most negative code maps to 32768
  function automatic logic [MAG_BITS-1:0] angle_mag(input logic [ANGLE_BITS-1:0] a);
    logic [MAG_BITS-1:0] ext;
    ext = {a[ANGLE_BITS-1], a};
    angle_mag = a[ANGLE_BITS-1] ? (MAG_BITS'(0) - ext) : ext;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/orientation_flip_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orientation_flip_detector: face-down flip detection on orientation samples
// Gates samples by time, keeps the latest level-pose time and a queue of
// flipped-pose times in a chain of cells, and gives a face-down verdict.
// ----------------------------------------------------------------------------
// Each item (timestamp, two Q3.13 angles) yields one result (face_down,
// sampled). An item is accepted in S_IDLE and its verdict is formed in
// S_EVAL once the output register is free; before that, a flipped pose
// needs a push step, and every expired face-up time a pop step, since
// the cell chain drops its head entry one per cycle. A new item is taken
// once the verdict of the previous one is in the output register, even if
// that result is still stalled. Configuration writes are always ready.
module orientation_flip_detector import ofd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration writes
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // input items
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [TIME_BITS-1:0]     timestamp_i,
  input  wire logic [ANGLE_BITS-1:0]    first_angle_i,
  input  wire logic [ANGLE_BITS-1:0]    second_angle_i,
  // result items
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          face_down_o,
  output logic                          sampled_o
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  // configuration registers
  logic [CFG_DATA_BITS-1:0] sample_interval_q;
  logic [CFG_DATA_BITS-1:0] window_length_q;
  logic [LIMIT_BITS-1:0]    flat_limit_q;
  logic [LIMIT_BITS-1:0]    flip_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_interval_q <= SAMPLE_INTERVAL_RST;
      window_length_q   <= WINDOW_LENGTH_RST;
      flat_limit_q      <= FLAT_LIMIT_RST;
      flip_limit_q      <= FLIP_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data_i;
        REG_WINDOW_LENGTH:   window_length_q   <= cfg_data_i;
        REG_FLAT_LIMIT:      flat_limit_q      <= cfg_data_i[LIMIT_BITS-1:0];
        REG_FLIP_LIMIT:      flip_limit_q      <= cfg_data_i[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // control state and result register
  state_e               state_q;
  logic [TIME_BITS-1:0] last_sample_q;
  logic [TIME_BITS-1:0] down_time_q;
  logic                 push_pend_q;
  logic                 sampled_q;
  logic                 out_valid_q;
  logic                 face_out_q;
  logic                 sampled_out_q;

  // cell chain
  logic                 cell_valid [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] cell_time  [QUEUE_DEPTH];
  cell_ctrl_t           cell_ctrl;

  logic                 in_accept;
  logic [TIME_BITS-1:0] gap;
  logic                 gate_pass;
  logic [MAG_BITS-1:0]  mag0, mag1;
  logic                 is_flat, is_flip;

  logic [TIME_BITS-1:0] head_age;
  logic                 head_expired;
  logic                 queue_full;
  logic [TIME_BITS-1:0] down_age;
  logic [TIME_BITS-1:0] down_lead;
  logic                 down_recent;
  logic                 verdict;
  logic                 out_free;
  logic                 finish;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign gap       = timestamp_i - last_sample_q;
  assign gate_pass = gap > TIME_BITS'(sample_interval_q);
  assign mag0      = angle_mag(first_angle_i);
  assign mag1      = angle_mag(second_angle_i);
  assign is_flat   = (mag0 < MAG_BITS'(flat_limit_q)) && (mag1 < MAG_BITS'(flat_limit_q));
  assign is_flip   = (mag0 > MAG_BITS'(flip_limit_q)) && (mag1 < MAG_BITS'(flat_limit_q));

  assign head_age     = last_sample_q - cell_time[0];
  assign head_expired = cell_valid[0] && (head_age > TIME_BITS'(window_length_q));
  assign queue_full   = cell_valid[QUEUE_DEPTH-1];

  assign down_age    = last_sample_q - down_time_q;
  assign down_lead   = down_time_q - last_sample_q;
  assign down_recent = down_age < TIME_BITS'(window_length_q);

  always_comb begin
    verdict = 1'b0;
    if (down_recent) begin
      if (cell_valid[0]) begin
        verdict = down_time_q > cell_time[0];
      end else begin
        verdict = (down_time_q > last_sample_q) && (down_lead > TIME_BITS'(1));
      end
    end
  end

  // drop expired heads first, then push, then drop again, then decide
  always_comb begin
    cell_ctrl = '0;
    if (state_q == S_EVAL) begin
      if (head_expired) begin
        cell_ctrl.pop = 1'b1;
      end else if (push_pend_q) begin
        cell_ctrl.push = 1'b1;
        cell_ctrl.pop  = queue_full;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == S_EVAL) && !head_expired && !push_pend_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      last_sample_q <= '0;
      down_time_q   <= '0;
      push_pend_q   <= 1'b0;
      sampled_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      face_out_q    <= 1'b0;
      sampled_out_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q     <= S_EVAL;
            sampled_q   <= gate_pass;
            push_pend_q <= gate_pass && is_flip;
            if (gate_pass) begin
              last_sample_q <= timestamp_i;
              if (is_flat) begin
                down_time_q <= timestamp_i;
              end
            end
          end
        end
        S_EVAL: begin
          if (cell_ctrl.push) begin
            push_pend_q <= 1'b0;
          end
          if (finish) begin
            state_q       <= S_IDLE;
            out_valid_q   <= 1'b1;
            face_out_q    <= verdict;
            sampled_out_q <= sampled_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 left_valid;
    logic                 right_valid;
    logic [TIME_BITS-1:0] right_time;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_time  = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_time  = cell_time[i+1];
    end

    ofd_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .push_time_i   (last_sample_q),
      .left_valid_i  (left_valid),
      .right_valid_i (right_valid),
      .right_time_i  (right_time),
      .valid_o       (cell_valid[i]),
      .time_o        (cell_time[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign face_down_o = face_out_q;
  assign sampled_o   = sampled_out_q;

endmodule
`default_nettype wire

FILE: rtl/ofd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofd_cell: one slot of the face-up time queue
// Holds one time and its valid bit. On a pop it takes its right neighbor's
// entry; on a push the first free cell loads the new time.
// ----------------------------------------------------------------------------
module ofd_cell import ofd_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic [TIME_BITS-1:0] push_time_i,
  input  wire logic                 left_valid_i,
  input  wire logic                 right_valid_i,
  input  wire logic [TIME_BITS-1:0] right_time_i,
  output logic                      valid_o,
  output logic [TIME_BITS-1:0]      time_o
);

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] time_q, time_d;

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      time_d  = right_time_i;
      // full queue: the cell that becomes the tail after the shift takes the push
      if (ctrl_i.push && valid_q && !right_valid_i) begin
        valid_d = 1'b1;
        time_d  = push_time_i;
      end
    end else if (ctrl_i.push && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      time_d  = push_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;

endmodule
`default_nettype wire

FILE: rtl/ofd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofd_checker: port-level checks of the orientation flip detector
// Watches the item handshakes of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module ofd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic face_down_o,
  input wire logic sampled_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(face_down_o) && $stable(sampled_o))
    else $error("stalled result changed or vanished");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous item still in work");

  // no result appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after accept");

  // a new result is only loaded while an item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in work");

endmodule

bind orientation_flip_detector ofd_checker u_ofd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .face_down_o (face_down_o),
  .sampled_o   (sampled_o)
);
`default_nettype wire

FILE: dv/orientation_flip_detector_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orientation_flip_detector_tb: self-checking bench of the flip detector
// Drives timestamped angle items and register writes with random idling on
// both channels. A scoreboard tracks the sample gate, the level-pose time and
// the face-up queue to predict every result, then compares field by field.
// ----------------------------------------------------------------------------
module orientation_flip_detector_tb;
  import ofd_pkg::*;

  localparam int unsigned QDEPTH = 128;
  localparam int unsigned TBITS  = 48;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 8'hA5;

  typedef struct packed {
    logic face_down;
    logic sampled;
  } verdict_t;

  typedef enum int {POSE_FLAT, POSE_FLIP, POSE_ANY} pose_kind_e;

  class flip_scoreboard;
    bit [CFG_DATA_BITS-1:0] interval_r;
    bit [CFG_DATA_BITS-1:0] window_r;
    bit [LIMIT_BITS-1:0]    flat_r;
    bit [LIMIT_BITS-1:0]    flip_r;
    bit [TBITS-1:0]         last_t;
    bit [TBITS-1:0]         down_t;
    bit [TBITS-1:0]         up_q[$];
    verdict_t               verdict_q[$];
    int                     errors;
    int                     checked;
    int                     n_sampled;
    int                     n_face;

    function new();
      interval_r = SAMPLE_INTERVAL_RST;
      window_r   = WINDOW_LENGTH_RST;
      flat_r     = FLAT_LIMIT_RST;
      flip_r     = FLIP_LIMIT_RST;
      last_t     = '0;
      down_t     = '0;
      errors     = 0;
      checked    = 0;
      n_sampled  = 0;
      n_face     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        REG_SAMPLE_INTERVAL: interval_r = d;
        REG_WINDOW_LENGTH:   window_r   = d;
        REG_FLAT_LIMIT:      flat_r     = d[LIMIT_BITS-1:0];
        REG_FLIP_LIMIT:      flip_r     = d[LIMIT_BITS-1:0];
        default: ;
      endcase
    endfunction

    // most negative code has magnitude 32768
    function bit [MAG_BITS-1:0] magnitude(bit [ANGLE_BITS-1:0] a);
      if (a[ANGLE_BITS-1]) return 17'h10000 - MAG_BITS'(a);
      return MAG_BITS'(a);
    endfunction

    function void drop_stale();
      bit [TBITS-1:0] age;
      while (up_q.size() > 0) begin
        age = last_t - up_q[0];
        if (age <= window_r) break;
        void'(up_q.pop_front());
      end
    endfunction

    function void note_input(bit [TBITS-1:0] ts, bit [ANGLE_BITS-1:0] a0,
                             bit [ANGLE_BITS-1:0] a1);
      bit [TBITS-1:0]    gap;
      bit [TBITS-1:0]    age;
      bit [MAG_BITS-1:0] m0;
      bit [MAG_BITS-1:0] m1;
      verdict_t          v;
      m0 = magnitude(a0);
      m1 = magnitude(a1);
      gap = ts - last_t;
      v.sampled = gap > interval_r;
      v.face_down = 1'b0;
      if (v.sampled) begin
        n_sampled++;
        last_t = ts;
        drop_stale();
        if (m0 < flat_r && m1 < flat_r) down_t = ts;
        if (m0 > flip_r && m1 < flat_r) begin
          if (up_q.size() >= QDEPTH) void'(up_q.pop_front());
          up_q.push_back(ts);
        end
      end
      drop_stale();
      age = last_t - down_t;
      if (age < window_r) begin
        if (up_q.size() > 0) v.face_down = down_t > up_q[0];
        // empty queue: compare against last sample time plus one, no wrap
        else v.face_down = (down_t > last_t) && ((down_t - last_t) > 1);
      end
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic face, logic smp);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing pending: face_down=%0b sampled=%0b",
                 $time, face, smp);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      checked++;
      if (v.face_down) n_face++;
      if (face !== v.face_down) begin
        $display("%0t: face_down mismatch: expected %0b, actual %0b",
                 $time, v.face_down, face);
        errors++;
      end
      if (smp !== v.sampled) begin
        $display("%0t: sampled mismatch: expected %0b, actual %0b",
                 $time, v.sampled, smp);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic [TBITS-1:0]         ts_drv    = '0;
  logic [ANGLE_BITS-1:0]    a0_drv    = '0;
  logic [ANGLE_BITS-1:0]    a1_drv    = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_ready;
  logic                     in_stall;
  logic                     out_valid;
  logic                     face_down;
  logic                     sampled;

  flip_scoreboard sb = new();

  logic [TBITS-1:0]         cur_ts  = '0;
  logic [CFG_DATA_BITS-1:0] cur_iv  = SAMPLE_INTERVAL_RST;
  logic [CFG_DATA_BITS-1:0] cur_win = WINDOW_LENGTH_RST;
  int                       cur_flat = FLAT_LIMIT_RST;
  int                       cur_flip = FLIP_LIMIT_RST;
  bit                       calm = 1'b0;
  int                       stall_left = 0;
  int                       n_items = 0;
  int                       n_settings = 0;

  orientation_flip_detector #(
    .QUEUE_DEPTH(QDEPTH),
    .TIME_BITS  (TBITS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .timestamp_i   (ts_drv),
    .first_angle_i (a0_drv),
    .second_angle_i(a1_drv),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .face_down_o   (face_down),
    .sampled_o     (sampled)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones; none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(ts_drv, a0_drv, a1_drv);
      if (out_valid && !out_stall) sb.check_result(face_down, sampled);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [ANGLE_BITS-1:0] angle_below(int lim);
    int m;
    if (lim == 0) return ANGLE_BITS'($urandom);
    m = $urandom_range(0, lim - 1);
    if ($urandom_range(0, 1)) return ANGLE_BITS'(-m);
    return ANGLE_BITS'(m);
  endfunction

  function automatic logic [ANGLE_BITS-1:0] angle_above(int lim);
    int m;
    m = $urandom_range(lim + 1, 32768);
    if ($urandom_range(0, 1)) return ANGLE_BITS'(-m);
    return ANGLE_BITS'(m);
  endfunction

  function automatic logic [ANGLE_BITS-1:0] any_angle();
    if ($urandom_range(0, 1)) return ANGLE_BITS'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return ANGLE_BITS'(25736);
      3: return ANGLE_BITS'(-25736);
      4: return ANGLE_BITS'(cur_flat);
      5: return ANGLE_BITS'(-cur_flat);
      6: return ANGLE_BITS'(cur_flat - 1);
      7: return ANGLE_BITS'(cur_flip);
      8: return ANGLE_BITS'(cur_flip + 1);
      default: return '0;
    endcase
  endfunction

  // advance the event time; biased toward steps just past the sample gate
  function automatic logic [TBITS-1:0] next_ts(bit gate_bias);
    logic [63:0] step;
    int          r;
    r = $urandom_range(0, 99);
    if (gate_bias && r < 75) begin
      step = 64'(cur_iv) + 1 + $urandom_range(0, cur_iv / 4 + 5);
      return TBITS'(64'(cur_ts) + step);
    end
    if (r < 8)       step = 0;
    else if (r < 20) step = $urandom_range(0, cur_iv);
    else if (r < 30) step = 64'(cur_iv);
    else if (r < 35) step = 64'(cur_iv) + 1;
    else if (r < 80) step = 64'(cur_iv) + 1 + $urandom_range(0, cur_iv / 4 + 5);
    else if (r < 88) step = $urandom_range(0, cur_win);
    else if (r < 93) step = 64'(cur_win) + $urandom_range(0, 1000);
    else if (r < 97) step = {$urandom, $urandom};
    else return TBITS'({$urandom, $urandom});
    return TBITS'(64'(cur_ts) + step);
  endfunction

  task automatic send_item(input logic [TBITS-1:0] t, input logic [ANGLE_BITS-1:0] x,
                           input logic [ANGLE_BITS-1:0] y);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ts_drv   <= t;
    a0_drv   <= x;
    a1_drv   <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cur_ts = t;
    n_items++;
  endtask

  task automatic send_pose(pose_kind_e k, bit gate_bias);
    logic [ANGLE_BITS-1:0] x;
    logic [ANGLE_BITS-1:0] y;
    case (k)
      POSE_FLAT: begin
        x = angle_below(cur_flat);
        y = angle_below(cur_flat);
      end
      POSE_FLIP: begin
        x = angle_above(cur_flip);
        y = angle_below(cur_flat);
      end
      default: begin
        x = any_angle();
        y = any_angle();
      end
    endcase
    send_item(next_ts(gate_bias), x, y);
  endtask

  // hold the sender until every pending verdict has been checked
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic configure_detector(input logic [CFG_DATA_BITS-1:0] iv,
                                    input logic [CFG_DATA_BITS-1:0] win,
                                    input int fl, input int fp, input bit stray);
    drain();
    repeat (4) @(posedge clk);
    cfg_write(REG_SAMPLE_INTERVAL, iv);
    cfg_write(REG_WINDOW_LENGTH, win);
    cfg_write(REG_FLAT_LIMIT, CFG_DATA_BITS'(fl));
    cfg_write(REG_FLIP_LIMIT, CFG_DATA_BITS'(fp));
    if (stray) cfg_write(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    cur_iv   = iv;
    cur_win  = win;
    cur_flat = fl;
    cur_flip = fp;
    n_settings++;
    @(posedge clk);
  endtask

  // mostly flip-then-level episodes with random content, the rest noise
  task automatic run_random(int count);
    int start;
    start = n_items;
    while (n_items - start < count) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if ($urandom_range(0, 59) == 0) drain();
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 4)) send_pose(POSE_FLIP, 1'b1);
        repeat ($urandom_range(1, 5)) send_pose(POSE_FLAT, 1'b1);
      end else begin
        send_pose(pose_kind_e'($urandom_range(0, 2)), 1'b0);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gate edges, angle extremes, wrapping timestamps
    send_item(48'd0, 16'h0000, 16'h0000);
    send_item(48'd30000, 16'h8000, 16'h0000);
    send_item(48'd60000, 16'h0000, 16'h0000);
    send_item(48'd60001, 16'h0000, 16'h0000);
    send_item(48'd90000, 16'h7FFF, ANGLE_BITS'(-2859));
    send_item(48'd120000, ANGLE_BITS'(2859), ANGLE_BITS'(-2859));
    send_item(48'd140001, ANGLE_BITS'(25736), ANGLE_BITS'(2860));
    send_item(48'd160001, 16'h0000, 16'h0000);
    send_item(48'd3000000, ANGLE_BITS'(-25736), 16'hFFFF);
    send_item(48'hFFFF_FFFF_FFFF, 16'h0000, 16'h7FFF);
    send_item(48'd5, 16'h0000, 16'h0000);
    send_item(48'h8000_0000_0000, ANGLE_BITS'(-2859), ANGLE_BITS'(2859));
    send_item(48'd100, 16'h8000, 16'h8000);
    send_item(48'hAAAA_AAAA_AAAA, 16'h8000, 16'h0001);
    send_item(48'h5555_5555_5555, 16'h0000, 16'h0000);

    // overfill the face-up queue, then level out
    configure_detector(32'd1000, 32'd500000, FLAT_LIMIT_RST, FLIP_LIMIT_RST, 1'b1);
    repeat (QDEPTH + 4) send_pose(POSE_FLIP, 1'b1);
    repeat (3) send_pose(POSE_FLAT, 1'b1);
    run_random(150);

    configure_detector(32'd0, 32'd0, 0, 0, 1'b0);
    run_random(150);

    // down time ahead of a wrapped sample time with an empty queue
    configure_detector(32'd0, 32'hFFFF_FFFF, FLAT_LIMIT_RST, FLIP_LIMIT_RST, 1'b0);
    send_item(48'hFFFF_FFFF_FFF6, 16'h0000, 16'h0000);
    send_item(48'd5, ANGLE_BITS'(12000), 16'h0000);
    run_random(150);

    configure_detector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 25736, 25736, 1'b0);
    run_random(150);

    repeat (4) begin
      configure_detector($urandom_range(0, 5000), $urandom_range(0, 300000),
                         $urandom_range(0, 25736), $urandom_range(0, 25736), 1'b1);
      run_random(140);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("%0d items over %0d register settings, %0d results checked",
             n_items, n_settings, sb.checked);
    $display("%0d items passed the sample gate, %0d face-down verdicts",
             sb.n_sampled, sb.n_face);
    if (sb.errors == 0) begin
      $display("orientation_flip_detector_tb: clean");
    end else begin
      $display("orientation_flip_detector_tb: errors");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout with %0d verdicts pending", sb.pending());
    $display("orientation_flip_detector_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
